// ===== src/scmd_pkg.sv =====
`timescale 1ns / 1ps

package scmd_pkg;

  localparam int MAX_LINE = 1024;
  localparam int POS_W    = $clog2(MAX_LINE + 1);
  localparam int OFF_W    = 10;
  localparam int TOK_W    = 11;
  localparam int LEN_W    = 11;

  // result queue
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef enum logic [3:0] {
    KIND_WORD       = 4'd0,
    KIND_PIPE       = 4'd1,
    KIND_OR         = 4'd2,
    KIND_BACKGROUND = 4'd3,
    KIND_AND        = 4'd4,
    KIND_OUT        = 4'd5,
    KIND_APPEND     = 4'd6,
    KIND_IN         = 4'd7,
    KIND_HEREDOC    = 4'd8,
    KIND_SEPARATOR  = 4'd9,
    KIND_END        = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_PIPE = 3'd1,
    OP_AMP  = 3'd2,
    OP_GT   = 3'd3,
    OP_LT   = 3'd4
  } op_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [OFF_W-1:0] start_res;
    logic [LEN_W-1:0] length;
    logic [TOK_W-1:0] tok_total;
    logic             overflow;
    logic             last;
  } out_item_t;

  // results of one input transaction, in order, n of them valid
  typedef struct packed {
    out_item_t [1:0] items;
    logic [1:0]      n;
  } step_res_t;

  function automatic op_t op_code(input logic [7:0] c);
    op_t r;
    unique case (c)
      CH_PIPE: r = OP_PIPE;
      CH_AMP:  r = OP_AMP;
      CH_GT:   r = OP_GT;
      CH_LT:   r = OP_LT;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic kind_t single_kind(input op_t op);
    kind_t r;
    unique case (op)
      OP_PIPE: r = KIND_PIPE;
      OP_AMP:  r = KIND_BACKGROUND;
      OP_GT:   r = KIND_OUT;
      OP_LT:   r = KIND_IN;
      default: r = KIND_WORD;
    endcase
    return r;
  endfunction

  function automatic kind_t double_kind(input op_t op);
    kind_t r;
    unique case (op)
      OP_PIPE: r = KIND_OR;
      OP_AMP:  r = KIND_AND;
      OP_GT:   r = KIND_APPEND;
      OP_LT:   r = KIND_HEREDOC;
      default: r = KIND_WORD;
    endcase
    return r;
  endfunction

  function automatic out_item_t mk_token(input kind_t k, input logic [OFF_W-1:0] s,
                                         input logic [LEN_W-1:0] len, input logic ovf);
    out_item_t r;
    r.kind        = k;
    r.start_res   = s;
    r.length      = len;
    r.tok_total   = '0;
    r.overflow    = ovf;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [TOK_W-1:0] sat_inc(input logic [TOK_W-1:0] t);
    return (t < TOK_W'(MAX_LINE)) ? t + TOK_W'(1) : t;
  endfunction

endpackage

// ===== src/scmd_lexer.sv =====
`timescale 1ns / 1ps

module scmd_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  scmd_pkg::in_item_t  item,
  output scmd_pkg::step_res_t res
);

  logic [scmd_pkg::POS_W-1:0] position, position_next;
  logic [scmd_pkg::OFF_W-1:0] word_start, word_start_next;
  logic                       in_word, in_word_next;
  logic                       quote_open, quote_open_next;
  logic                       quote_is_single, quote_is_single_next;
  logic                       prev_backslash, prev_backslash_next;
  scmd_pkg::op_t              held, held_next;
  logic [scmd_pkg::OFF_W-1:0] held_position, held_position_next;
  logic [scmd_pkg::TOK_W-1:0] tokens, tokens_next;
  logic                       overflowed, overflowed_next;

  logic [7:0]                 c;
  logic                       line_end;
  scmd_pkg::op_t              code;
  logic                       at_limit;
  logic                       ovf_n;
  logic [scmd_pkg::OFF_W-1:0] offset;
  logic                       is_quote;
  logic                       is_delim;
  logic                       doubled;
  logic [1:0]                 k;
  logic [scmd_pkg::LEN_W-1:0] word_len;

  assign c        = item.byte_in;
  assign line_end = item.is_end || (c == scmd_pkg::CH_NUL);
  assign code     = scmd_pkg::op_code(c);
  assign at_limit = position >= scmd_pkg::POS_W'(scmd_pkg::MAX_LINE);
  assign ovf_n    = overflowed | at_limit;
  assign offset   = at_limit ? scmd_pkg::OFF_W'(scmd_pkg::MAX_LINE - 1)
                             : position[scmd_pkg::OFF_W-1:0];
  assign is_quote = ((c == scmd_pkg::CH_DQUOTE) || (c == scmd_pkg::CH_SQUOTE))
                    && !prev_backslash;
  assign is_delim = (c == scmd_pkg::CH_SPACE) || (c == scmd_pkg::CH_TAB)
                    || (c == scmd_pkg::CH_NL) || (code != scmd_pkg::OP_NONE)
                    || (c == scmd_pkg::CH_SEMI);
  assign doubled  = (held != scmd_pkg::OP_NONE) && (held == code);
  // position never exceeds the line limit, so the difference fits
  assign word_len = scmd_pkg::LEN_W'(position - scmd_pkg::POS_W'(word_start));

  always_comb begin
    position_next        = position;
    word_start_next      = word_start;
    in_word_next         = in_word;
    quote_open_next      = quote_open;
    quote_is_single_next = quote_is_single;
    prev_backslash_next  = prev_backslash;
    held_next            = held;
    held_position_next   = held_position;
    tokens_next          = tokens;
    overflowed_next      = overflowed;
    res                  = '0;
    k                    = 2'd0;

    if (line_end) begin
      if (held != scmd_pkg::OP_NONE) begin
        res.items[0] = scmd_pkg::mk_token(scmd_pkg::single_kind(held), held_position,
                                          scmd_pkg::LEN_W'(1), overflowed);
        tokens_next  = scmd_pkg::sat_inc(tokens);
        k            = 2'd1;
      end else if (in_word && !quote_open) begin
        res.items[0] = scmd_pkg::mk_token(scmd_pkg::KIND_WORD, word_start, word_len,
                                          overflowed);
        tokens_next  = scmd_pkg::sat_inc(tokens);
        k            = 2'd1;
      end
      res.items[k[0]]           = '0;
      res.items[k[0]].kind      = scmd_pkg::KIND_END;
      res.items[k[0]].tok_total = tokens_next;
      res.items[k[0]].overflow  = overflowed;
      res.items[k[0]].last      = 1'b1;
      k                         = k + 2'd1;
      // back to the reset state for the next line
      position_next        = '0;
      word_start_next      = '0;
      in_word_next         = 1'b0;
      quote_open_next      = 1'b0;
      quote_is_single_next = 1'b0;
      prev_backslash_next  = 1'b0;
      held_next            = scmd_pkg::OP_NONE;
      held_position_next   = '0;
      tokens_next          = '0;
      overflowed_next      = 1'b0;
    end else begin
      overflowed_next     = ovf_n;
      prev_backslash_next = (c == scmd_pkg::CH_BSLASH);
      if (!at_limit) begin
        position_next = position + scmd_pkg::POS_W'(1);
      end
      if (held != scmd_pkg::OP_NONE) begin
        held_next = scmd_pkg::OP_NONE;
        if (doubled) begin
          res.items[0] = scmd_pkg::mk_token(scmd_pkg::double_kind(held), held_position,
                                            scmd_pkg::LEN_W'(2), ovf_n);
        end else begin
          res.items[0] = scmd_pkg::mk_token(scmd_pkg::single_kind(held), held_position,
                                            scmd_pkg::LEN_W'(1), ovf_n);
        end
        tokens_next = scmd_pkg::sat_inc(tokens_next);
        k           = 2'd1;
      end
      if (!doubled) begin
        if (is_quote) begin
          if (!quote_open) begin
            quote_open_next      = 1'b1;
            quote_is_single_next = (c == scmd_pkg::CH_SQUOTE);
          end else if ((c == scmd_pkg::CH_SQUOTE) == quote_is_single) begin
            quote_open_next = 1'b0;
          end
        end
        if (quote_open_next || !is_delim) begin
          if (!in_word) begin
            in_word_next    = 1'b1;
            word_start_next = offset;
          end
        end else begin
          if (in_word) begin
            res.items[k[0]] = scmd_pkg::mk_token(scmd_pkg::KIND_WORD, word_start, word_len,
                                                 ovf_n);
            tokens_next     = scmd_pkg::sat_inc(tokens_next);
            k               = k + 2'd1;
            in_word_next    = 1'b0;
          end
          if (code != scmd_pkg::OP_NONE) begin
            held_next          = code;
            held_position_next = offset;
          end else if (c == scmd_pkg::CH_SEMI) begin
            res.items[k[0]] = scmd_pkg::mk_token(scmd_pkg::KIND_SEPARATOR, offset,
                                                 scmd_pkg::LEN_W'(1), ovf_n);
            tokens_next     = scmd_pkg::sat_inc(tokens_next);
            k               = k + 2'd1;
          end
        end
      end
    end
    res.n = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      word_start      <= '0;
      in_word         <= 1'b0;
      quote_open      <= 1'b0;
      quote_is_single <= 1'b0;
      prev_backslash  <= 1'b0;
      held            <= scmd_pkg::OP_NONE;
      held_position   <= '0;
      tokens          <= '0;
      overflowed      <= 1'b0;
    end else if (fire) begin
      position        <= position_next;
      word_start      <= word_start_next;
      in_word         <= in_word_next;
      quote_open      <= quote_open_next;
      quote_is_single <= quote_is_single_next;
      prev_backslash  <= prev_backslash_next;
      held            <= held_next;
      held_position   <= held_position_next;
      tokens          <= tokens_next;
      overflowed      <= overflowed_next;
    end
  end

  // an operator is only held after any open word has been closed
  a_held_no_word: assert property (@(posedge clk) disable iff (rst)
    !((held != scmd_pkg::OP_NONE) && in_word))
    else $error("operator held while a word is open");

  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    position <= scmd_pkg::POS_W'(scmd_pkg::MAX_LINE))
    else $error("position beyond line limit");

  // every end of line leaves the lexer in its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && line_end) |=> (position == '0) && (tokens == '0) && !in_word && !quote_open
                           && (held == scmd_pkg::OP_NONE) && !overflowed)
    else $error("state not cleared after end of line");

endmodule

// ===== src/scmd_outq.sv =====
`timescale 1ns / 1ps

module scmd_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scmd_pkg::step_res_t res,
  output logic                room,
  output logic                result_valid,
  input  logic                result_ready,
  output scmd_pkg::out_item_t result
);

  scmd_pkg::out_item_t       mem [scmd_pkg::Q_DEPTH];
  logic [scmd_pkg::Q_AW-1:0] wr_ptr, wr_ptr_next;
  logic [scmd_pkg::Q_AW-1:0] rd_ptr, rd_ptr_next;
  logic [scmd_pkg::Q_CW-1:0] count, count_next;
  logic [1:0]                push_n;
  logic                      pop;

  assign push_n       = push ? res.n : 2'd0;
  assign pop          = result_valid && result_ready;
  assign result_valid = count != '0;
  assign result       = mem[rd_ptr];
  // one transaction may add two records
  assign room         = count <= scmd_pkg::Q_CW'(scmd_pkg::Q_DEPTH - 2);

  assign wr_ptr_next = wr_ptr + scmd_pkg::Q_AW'(push_n);
  assign rd_ptr_next = rd_ptr + scmd_pkg::Q_AW'(pop);
  assign count_next  = count + scmd_pkg::Q_CW'(push_n) - scmd_pkg::Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= res.items[0];
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + scmd_pkg::Q_AW'(1)] <= res.items[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> (count <= scmd_pkg::Q_CW'(scmd_pkg::Q_DEPTH - 2)))
    else $error("records pushed without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd0 && !pop) |=> $stable(count))
    else $error("queue count moved without a transaction");

endmodule

// ===== src/shell_command_tokenizer.sv =====
`timescale 1ns / 1ps

// Streaming lexer for one shell command line. Each input transaction carries one
// byte; a zero byte or is_end closes the line, flushes a held operator or an open
// unquoted word, emits an end record with the token count and clears all state.
// Bytes are taken one per cycle: a byte lands in an input register, the lexer
// decides its zero, one or two token records combinationally and they go into a
// four-entry result queue that feeds the output; a byte passes the input register
// and its records pass the queue before output. A byte that yields two records
// writes both into the queue together; input is held off only while the queue has
// fewer than two free entries, so with the output always ready the input runs at
// one byte per cycle. Positions saturate at 1023 and set the overflow flag.

module shell_command_tokenizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  scmd_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output scmd_pkg::out_item_t result
);

  logic                pend_valid;
  scmd_pkg::in_item_t  pend_item;
  logic                step_fire;
  logic                q_room;
  scmd_pkg::step_res_t step_res;

  assign step_fire  = pend_valid && q_room;
  assign item_ready = !pend_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (item_ready) begin
      pend_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      pend_item <= item;
    end
  end

  scmd_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .fire (step_fire),
    .item (pend_item),
    .res  (step_res)
  );

  scmd_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (step_fire),
    .res          (step_res),
    .room         (q_room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // a byte that produces records leaves the output valid in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (step_fire && step_res.n != 2'd0) |=> result_valid)
    else $error("records of a transaction not visible");

  a_end_record_count: assert property (@(posedge clk) disable iff (rst)
    step_fire |-> (step_res.n <= 2'd2))
    else $error("more than two records for one transaction");

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !step_fire) |=> pend_valid && $stable(pend_item))
    else $error("pending byte lost while stalled");

endmodule
